/* sv/tcc_pkg.sv */
// shared constants, codes and item types for the text console cursor engine
package tcc_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_LINES   = 128;
    localparam int MAX_DIGITS  = 4;
    localparam int TAB_STOP    = 4;

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ROW_W   = $clog2(MAX_LINES);
    localparam int COLS_W  = COL_W + 1;
    localparam int LINES_W = ROW_W + 1;
    localparam int STOP_W  = $clog2(MAX_COLUMNS + TAB_STOP + 1);
    localparam int DCNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W  = $clog2(MAX_DIGITS);
    localparam int REP_W   = $clog2(MAX_DIGITS + 3);
    localparam int CODE_W  = 4 * MAX_DIGITS;
    localparam int COLOR_W = 32;
    localparam int BYTE_W  = 8;
    localparam int GLYPH_W = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0]  ESC_BYTE      = 8'h1B;
    localparam logic [BYTE_W-1:0]  BRACKET_BYTE  = 8'h5B;
    localparam logic [BYTE_W-1:0]  SGR_END_BYTE  = 8'h6D;
    localparam logic [BYTE_W-1:0]  LF_BYTE       = 8'h0A;
    localparam logic [BYTE_W-1:0]  CR_BYTE       = 8'h0D;
    localparam logic [BYTE_W-1:0]  TAB_BYTE      = 8'h09;
    localparam logic [BYTE_W-1:0]  BS_BYTE       = 8'h08;
    localparam logic [BYTE_W-1:0]  SPACE_BYTE    = 8'h20;
    localparam logic [BYTE_W-1:0]  DIGIT0_BYTE   = 8'h30;
    localparam logic [BYTE_W-1:0]  DIGIT9_BYTE   = 8'h39;
    localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 7'h3F;

    localparam logic [CODE_W-1:0] SGR_RESET  = CODE_W'(0);
    localparam logic [CODE_W-1:0] SGR_ACCENT = CODE_W'(1);
    localparam logic [CODE_W-1:0] SGR_DIM    = CODE_W'(2);
    localparam logic [CODE_W-1:0] SGR_ERROR  = CODE_W'(31);

    typedef enum logic [2:0] {
        CFG_ENABLE     = 3'd0,
        CFG_COLUMNS    = 3'd1,
        CFG_LINES      = 3'd2,
        CFG_DEFAULT    = 3'd3,
        CFG_ACCENT     = 3'd4,
        CFG_DIM        = 3'd5,
        CFG_ERROR      = 3'd6,
        CFG_BACKGROUND = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        INK_DEFAULT = 2'd0,
        INK_ACCENT  = 2'd1,
        INK_DIM     = 2'd2,
        INK_ERROR   = 2'd3
    } t_ink;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_SCROLL = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_LF   = 3'd1,
        ACT_CR   = 3'd2,
        ACT_TAB  = 3'd3,
        ACT_BS   = 3'd4,
        ACT_DRAW = 3'd5
    } t_act;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              string_end;
    } t_in_item;

    typedef struct packed {
        t_cmd               command;
        logic [COL_W-1:0]   cell_column;
        logic [ROW_W-1:0]   cell_row;
        logic [GLYPH_W-1:0] glyph_code;
        logic [COLOR_W-1:0] ink_color;
        logic [COLOR_W-1:0] paper_color;
        logic               final_result;
    } t_out_item;

    typedef struct packed {
        logic               enable;
        logic [COLS_W-1:0]  columns;
        logic [LINES_W-1:0] lines;
        logic [COLOR_W-1:0] color_default;
        logic [COLOR_W-1:0] color_accent;
        logic [COLOR_W-1:0] color_dim;
        logic [COLOR_W-1:0] color_error;
        logic [COLOR_W-1:0] color_background;
    } t_cfg;

    typedef struct packed {
        logic [REP_W-1:0]            rep_len;
        logic [MAX_DIGITS-1:0][3:0]  digits;
        t_act                        act;
        logic [BYTE_W-1:0]           ch;
        t_ink                        ink;
    } t_job;

endpackage

/* sv/tcc_front.sv */
// escape sequence parser that turns each accepted byte into a job while the console is enabled
module tcc_front import tcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  logic     i_enable,
    output logic     o_job_push,
    output t_job     o_job
);

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_SEEN = 3'b010,
        ESC_CSI  = 3'b100
    } t_esc;

    t_esc                       r_phase, n_phase;
    logic [DCNT_W-1:0]          r_count, n_count;
    t_ink                       r_ink, n_ink;
    logic [MAX_DIGITS-1:0][3:0] r_digits, n_digits;
    logic [CODE_W-1:0]          code;
    logic                       do_fresh;
    logic [BYTE_W-1:0]          b;
    logic                       last;
    logic                       is_digit;

    assign b          = i_item.text_byte;
    assign last       = i_item.string_end;
    assign is_digit   = (b >= DIGIT0_BYTE) && (b <= DIGIT9_BYTE);
    assign o_job_push = i_accept && i_enable;

    // sgr value from the stored digits
    always_comb begin
        code = '0;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (DCNT_W'(k) < r_count) begin
                code = (code << 3) + (code << 1) + CODE_W'(r_digits[k]);
            end
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_ink    = r_ink;
        n_digits = r_digits;
        do_fresh = 1'b0;
        o_job.rep_len = '0;
        o_job.act     = ACT_NONE;
        o_job.ch      = b;
        o_job.ink     = r_ink;
        unique case (r_phase)
            ESC_IDLE: begin
                do_fresh = 1'b1;
            end
            ESC_SEEN: begin
                if (b == BRACKET_BYTE) begin
                    n_count = '0;
                    if (last) begin
                        o_job.rep_len = REP_W'(2);
                        n_phase       = ESC_IDLE;
                    end else begin
                        n_phase = ESC_CSI;
                    end
                end else begin
                    o_job.rep_len = REP_W'(1);
                    n_phase       = ESC_IDLE;
                    n_count       = '0;
                    do_fresh      = 1'b1;
                end
            end
            ESC_CSI: begin
                if (is_digit) begin
                    if (r_count < DCNT_W'(MAX_DIGITS)) begin
                        n_digits[r_count[DIDX_W-1:0]] = b[3:0];
                        n_count = r_count + DCNT_W'(1);
                        if (last) begin
                            o_job.rep_len = REP_W'(2) + REP_W'(n_count);
                            n_phase       = ESC_IDLE;
                            n_count       = '0;
                        end
                    end else begin
                        o_job.rep_len = REP_W'(2) + REP_W'(MAX_DIGITS);
                        o_job.act     = ACT_DRAW;
                        n_phase       = ESC_IDLE;
                        n_count       = '0;
                    end
                end else if (b == SGR_END_BYTE) begin
                    priority if (code == SGR_RESET) begin
                        n_ink = INK_DEFAULT;
                    end else if (code == SGR_ACCENT) begin
                        n_ink = INK_ACCENT;
                    end else if (code == SGR_DIM) begin
                        n_ink = INK_DIM;
                    end else if (code == SGR_ERROR) begin
                        n_ink = INK_ERROR;
                    end else begin
                        n_ink = r_ink;
                    end
                    n_phase = ESC_IDLE;
                    n_count = '0;
                end else begin
                    o_job.rep_len = REP_W'(2) + REP_W'(r_count);
                    n_phase       = ESC_IDLE;
                    n_count       = '0;
                    do_fresh      = 1'b1;
                end
            end
            default: begin
                n_phase = ESC_IDLE;
            end
        endcase

        if (do_fresh) begin
            if (b == ESC_BYTE) begin
                if (last) begin
                    o_job.act = ACT_DRAW;
                end else begin
                    n_phase = ESC_SEEN;
                    n_count = '0;
                end
            end else begin
                priority if (b == LF_BYTE) begin
                    o_job.act = ACT_LF;
                end else if (b == CR_BYTE) begin
                    o_job.act = ACT_CR;
                end else if (b == TAB_BYTE) begin
                    o_job.act = ACT_TAB;
                end else if (b == BS_BYTE) begin
                    o_job.act = ACT_BS;
                end else begin
                    o_job.act = ACT_DRAW;
                end
            end
        end
        o_job.digits = n_digits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_count <= '0;
            r_ink   <= INK_DEFAULT;
        end else if (o_job_push) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_ink   <= n_ink;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_push) begin
            r_digits <= n_digits;
        end
    end

endmodule

/* sv/tcc_job_queue.sv */
// two-entry queue of jobs between the parser and the cursor sequencer
module tcc_job_queue import tcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_data
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/tcc_back.sv */
// cursor sequencer that carries out jobs and emits cell commands
module tcc_back import tcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_job_empty,
    input  t_job      i_job,
    output logic      o_job_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res_item
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_REPLAY = 6'b000010,
        ST_ACT    = 6'b000100,
        ST_TAB    = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    t_job               r_job, n_job;
    logic [REP_W-1:0]   r_idx, n_idx;
    logic [STOP_W-1:0]  r_stop, n_stop;
    logic               r_pend_valid, n_pend_valid;
    t_out_item          r_pend, n_pend;

    logic [COLS_W-1:0]  cols_eff;
    logic [LINES_W-1:0] lines_eff;
    logic [COLS_W-1:0]  col_inc;
    logic [LINES_W-1:0] row_inc;
    logic               wrap;
    logic               at_bottom;
    logic               go;
    logic [COLOR_W-1:0] ink;
    logic [REP_W-1:0]   idx_m2;
    logic [REP_W-1:0]   idx_inc;
    logic [BYTE_W-1:0]  rep_ch;
    logic [BYTE_W-1:0]  cur_ch;
    t_out_item          draw_item;
    t_out_item          emit_item;
    logic               emit_en;
    logic               do_draw;
    logic               finish;
    t_state             after_rep;

    always_comb begin
        if (i_cfg.columns == '0) begin
            cols_eff = COLS_W'(1);
        end else if (i_cfg.columns > COLS_W'(MAX_COLUMNS)) begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end else begin
            cols_eff = i_cfg.columns;
        end
        if (i_cfg.lines == '0) begin
            lines_eff = LINES_W'(1);
        end else if (i_cfg.lines > LINES_W'(MAX_LINES)) begin
            lines_eff = LINES_W'(MAX_LINES);
        end else begin
            lines_eff = i_cfg.lines;
        end
    end

    assign col_inc   = {1'b0, r_col} + COLS_W'(1);
    assign row_inc   = {1'b0, r_row} + LINES_W'(1);
    assign wrap      = (col_inc >= cols_eff);
    assign at_bottom = (row_inc >= lines_eff);
    assign go        = !(r_pend_valid && i_res_full);
    assign idx_m2    = r_idx - REP_W'(2);
    assign idx_inc   = r_idx + REP_W'(1);
    assign after_rep = (idx_inc == r_job.rep_len) ? ST_ACT : ST_REPLAY;

    always_comb begin
        unique case (r_job.ink)
            INK_ACCENT: ink = i_cfg.color_accent;
            INK_DIM:    ink = i_cfg.color_dim;
            INK_ERROR:  ink = i_cfg.color_error;
            default:    ink = i_cfg.color_default;
        endcase
    end

    always_comb begin
        if (r_idx == '0) begin
            rep_ch = ESC_BYTE;
        end else if (r_idx == REP_W'(1)) begin
            rep_ch = BRACKET_BYTE;
        end else begin
            rep_ch = DIGIT0_BYTE + BYTE_W'(r_job.digits[idx_m2[DIDX_W-1:0]]);
        end
        if (r_state == ST_REPLAY) begin
            cur_ch = rep_ch;
        end else if (r_state == ST_TAB) begin
            cur_ch = SPACE_BYTE;
        end else begin
            cur_ch = r_job.ch;
        end
        draw_item.command      = CMD_DRAW;
        draw_item.cell_column  = r_col;
        draw_item.cell_row     = r_row;
        draw_item.glyph_code   = cur_ch[BYTE_W-1] ? GLYPH_UNKNOWN : cur_ch[GLYPH_W-1:0];
        draw_item.ink_color    = ink;
        draw_item.paper_color  = i_cfg.color_background;
        draw_item.final_result = 1'b0;
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_col     = r_col;
        n_row     = r_row;
        n_job     = r_job;
        n_idx     = r_idx;
        n_stop    = r_stop;
        o_job_pop = 1'b0;
        emit_en   = 1'b0;
        do_draw   = 1'b0;
        finish    = 1'b0;
        emit_item = draw_item;

        if (go) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        o_job_pop = 1'b1;
                        n_job     = i_job;
                        n_idx     = '0;
                        if ({1'b0, r_col} >= cols_eff) begin
                            n_col = COL_W'(cols_eff - COLS_W'(1));
                        end
                        if ({1'b0, r_row} >= lines_eff) begin
                            n_row = ROW_W'(lines_eff - LINES_W'(1));
                        end
                        n_state = (i_job.rep_len != '0) ? ST_REPLAY : ST_ACT;
                    end
                end
                ST_REPLAY: begin
                    do_draw = 1'b1;
                    n_idx   = idx_inc;
                    if (wrap && at_bottom) begin
                        n_state = ST_SCROLL;
                        n_ret   = after_rep;
                    end else begin
                        n_state = after_rep;
                    end
                end
                ST_SCROLL: begin
                    emit_en                = 1'b1;
                    emit_item.command      = CMD_SCROLL;
                    emit_item.cell_column  = '0;
                    emit_item.cell_row     = '0;
                    emit_item.glyph_code   = '0;
                    emit_item.ink_color    = '0;
                    n_state                = r_ret;
                end
                ST_ACT: begin
                    n_state = ST_DONE;
                    unique case (r_job.act)
                        ACT_LF: begin
                            n_col = '0;
                            if (at_bottom) begin
                                n_state = ST_SCROLL;
                                n_ret   = ST_DONE;
                            end else begin
                                n_row = ROW_W'(row_inc);
                            end
                        end
                        ACT_CR: begin
                            n_col = '0;
                        end
                        ACT_TAB: begin
                            n_stop  = STOP_W'((32'(r_col) / TAB_STOP + 1) * TAB_STOP);
                            n_state = ST_TAB;
                        end
                        ACT_BS: begin
                            if (r_col != '0) begin
                                n_col                 = r_col - COL_W'(1);
                                emit_en               = 1'b1;
                                emit_item.command     = CMD_CLEAR;
                                emit_item.cell_column = r_col - COL_W'(1);
                                emit_item.glyph_code  = '0;
                                emit_item.ink_color   = '0;
                            end
                        end
                        ACT_DRAW: begin
                            do_draw = 1'b1;
                            if (wrap && at_bottom) begin
                                n_state = ST_SCROLL;
                                n_ret   = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
                ST_TAB: begin
                    if ((STOP_W'(r_col) < r_stop) && ({1'b0, r_col} < cols_eff)) begin
                        do_draw = 1'b1;
                        if (wrap) begin
                            if (at_bottom) begin
                                n_state = ST_SCROLL;
                                n_ret   = ST_DONE;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                    end else begin
                        n_state = ST_DONE;
                    end
                end
                ST_DONE: begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase

            if (do_draw) begin
                emit_en = 1'b1;
                if (wrap) begin
                    n_col = '0;
                    if (!at_bottom) begin
                        n_row = ROW_W'(row_inc);
                    end
                end else begin
                    n_col = COL_W'(col_inc);
                end
            end
        end
    end

    // one result is held back so the last one of a job can be flagged
    always_comb begin
        o_res_push   = 1'b0;
        o_res_item   = r_pend;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (emit_en) begin
            o_res_push   = r_pend_valid;
            n_pend       = emit_item;
            n_pend_valid = 1'b1;
        end
        if (finish && r_pend_valid) begin
            o_res_push              = 1'b1;
            o_res_item.final_result = 1'b1;
            n_pend_valid            = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_DONE;
            r_col        <= '0;
            r_row        <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ret        <= n_ret;
            r_col        <= n_col;
            r_row        <= n_row;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_stop <= n_stop;
        r_pend <= n_pend;
    end

endmodule

/* sv/tcc_result_queue.sv */
// two-entry queue of cell commands toward the result side
module tcc_result_queue import tcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_data
);

    t_out_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/text_console_cursor_engine_top.sv */
// top level of the text console cursor engine: configuration registers and block wiring
//
// Text bytes go in through a queue-style port (push/full) and cell commands come
// out the same way (empty/pop). The parser takes one byte per cycle while its
// two-entry job queue has room; the cursor sequencer then takes each job through
// a fetch, act and finish step, plus a replay step for every glyph it draws out
// of a replayed escape sequence and a scroll step for every scroll; a tab adds a
// tab step per space and one more when it ends on its stop rather than on a wrap.
// Results pass through one holding register and a two-entry output queue; a full
// output queue stalls the sequencer. Configuration writes take effect at once and
// are meant for idle periods.
module text_console_cursor_engine_top import tcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_in_item           i_in_item,
    output logic               empty,
    input  logic               pop,
    output t_out_item          o_out_item,
    input  logic               i_cfg_wr_en,
    input  t_cfg_index         i_cfg_index,
    input  logic [COLOR_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      accept;
    logic      job_push;
    t_job      job_in;
    logic      job_full;
    logic      job_empty;
    t_job      job_out;
    logic      job_pop;
    logic      res_push;
    t_out_item res_item;
    logic      res_full;

    assign full   = job_full;
    assign accept = push && !job_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable           <= 1'b0;
            r_cfg.columns          <= COLS_W'(80);
            r_cfg.lines            <= LINES_W'(48);
            r_cfg.color_default    <= 32'h00FF_FFFF;
            r_cfg.color_accent     <= 32'h0000_FFFF;
            r_cfg.color_dim        <= 32'h0080_8080;
            r_cfg.color_error      <= 32'h00FF_0000;
            r_cfg.color_background <= 32'h0000_0000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLE:     r_cfg.enable           <= i_cfg_data[0];
                CFG_COLUMNS:    r_cfg.columns          <= i_cfg_data[COLS_W-1:0];
                CFG_LINES:      r_cfg.lines            <= i_cfg_data[LINES_W-1:0];
                CFG_DEFAULT:    r_cfg.color_default    <= i_cfg_data;
                CFG_ACCENT:     r_cfg.color_accent     <= i_cfg_data;
                CFG_DIM:        r_cfg.color_dim        <= i_cfg_data;
                CFG_ERROR:      r_cfg.color_error      <= i_cfg_data;
                CFG_BACKGROUND: r_cfg.color_background <= i_cfg_data;
                default:        r_cfg.enable           <= r_cfg.enable;
            endcase
        end
    end

    tcc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .i_enable   (r_cfg.enable),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    tcc_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    tcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_item  (res_item)
    );

    tcc_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_out_item)
    );

endmodule

/* dv/tcc_command_checker.sv */
// checker that predicts cell commands from accepted text bytes and compares the results
`timescale 1ns / 100ps
module tcc_command_checker import tcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  t_in_item           i_in_item,
    input  logic               i_empty,
    input  logic               i_pop,
    input  t_out_item          i_out_item,
    input  logic               i_cfg_wr_en,
    input  t_cfg_index         i_cfg_index,
    input  logic [COLOR_W-1:0] i_cfg_data,
    output int                 o_failures,
    output int                 o_pending
);

    localparam int RESULT_LIMIT = 20;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_ESC  = 2'd1,
        SEQ_CSI  = 2'd2
    } t_seq;

    logic               console_on;
    logic [COLS_W-1:0]  screen_columns;
    logic [LINES_W-1:0] screen_lines;
    logic [COLOR_W-1:0] ink_default;
    logic [COLOR_W-1:0] ink_accent;
    logic [COLOR_W-1:0] ink_dim;
    logic [COLOR_W-1:0] ink_error;
    logic [COLOR_W-1:0] paper;

    int                 cursor_col;
    int                 cursor_row;
    t_ink               ink_sel;
    t_seq               seq_state;
    logic [3:0]         digit_buf [MAX_DIGITS];
    int                 digit_cnt;

    t_out_item          byte_cells [$];
    t_out_item          expected_cells [$];

    function automatic int screen_cols();
        if (screen_columns == 0) return 1;
        if (screen_columns > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(screen_columns);
    endfunction

    function automatic int screen_rows();
        if (screen_lines == 0) return 1;
        if (screen_lines > MAX_LINES) return MAX_LINES;
        return int'(screen_lines);
    endfunction

    function automatic logic [COLOR_W-1:0] current_ink();
        case (ink_sel)
            INK_ACCENT: return ink_accent;
            INK_DIM:    return ink_dim;
            INK_ERROR:  return ink_error;
            default:    return ink_default;
        endcase
    endfunction

    function automatic void add_cell(input t_cmd cmd, input int col, input int row,
                                     input int glyph, input logic [COLOR_W-1:0] ink);
        t_out_item entry;
        if (byte_cells.size() >= RESULT_LIMIT) return;
        entry.command      = cmd;
        entry.cell_column  = COL_W'(col);
        entry.cell_row     = ROW_W'(row);
        entry.glyph_code   = GLYPH_W'(glyph);
        entry.ink_color    = ink;
        entry.paper_color  = paper;
        entry.final_result = 1'b0;
        byte_cells.push_back(entry);
    endfunction

    function automatic void new_line();
        cursor_col = 0;
        if (cursor_row + 1 >= screen_rows()) begin
            add_cell(CMD_SCROLL, 0, 0, 0, '0);
        end else begin
            cursor_row++;
        end
    endfunction

    // returns 1 when the glyph wrapped the line
    function automatic bit put_glyph(input int code);
        int glyph;
        glyph = (code >= 128) ? int'(GLYPH_UNKNOWN) : code;
        add_cell(CMD_DRAW, cursor_col, cursor_row, glyph, current_ink());
        cursor_col++;
        if (cursor_col >= screen_cols()) begin
            new_line();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void act_on_text(input int code);
        int stop;
        if (code == LF_BYTE) begin
            new_line();
        end else if (code == CR_BYTE) begin
            cursor_col = 0;
        end else if (code == TAB_BYTE) begin
            stop = (cursor_col / TAB_STOP + 1) * TAB_STOP;
            while (cursor_col < stop && cursor_col < screen_cols()) begin
                if (put_glyph(SPACE_BYTE)) break;
            end
        end else if (code == BS_BYTE) begin
            if (cursor_col != 0) begin
                cursor_col--;
                add_cell(CMD_CLEAR, cursor_col, cursor_row, 0, '0);
            end
        end else begin
            void'(put_glyph(code));
        end
    endfunction

    // pending escape bytes go out as plain glyphs
    function automatic void replay_sequence();
        if (seq_state != SEQ_IDLE) void'(put_glyph(ESC_BYTE));
        if (seq_state == SEQ_CSI) begin
            void'(put_glyph(BRACKET_BYTE));
            for (int k = 0; k < digit_cnt && k < MAX_DIGITS; k++) begin
                void'(put_glyph(DIGIT0_BYTE + digit_buf[k]));
            end
        end
        seq_state = SEQ_IDLE;
        digit_cnt = 0;
    endfunction

    function automatic void apply_color_code();
        int code;
        code = 0;
        for (int k = 0; k < digit_cnt && k < MAX_DIGITS; k++) begin
            code = code * 10 + digit_buf[k];
        end
        if (code == SGR_RESET) ink_sel = INK_DEFAULT;
        else if (code == SGR_ACCENT) ink_sel = INK_ACCENT;
        else if (code == SGR_DIM) ink_sel = INK_DIM;
        else if (code == SGR_ERROR) ink_sel = INK_ERROR;
        seq_state = SEQ_IDLE;
        digit_cnt = 0;
    endfunction

    function automatic void start_fresh(input int code, input logic last);
        if (code == ESC_BYTE) begin
            if (last) begin
                void'(put_glyph(ESC_BYTE));
            end else begin
                seq_state = SEQ_ESC;
                digit_cnt = 0;
            end
        end else begin
            act_on_text(code);
        end
    endfunction

    function automatic void predict_cell_commands(input t_in_item item);
        int        code;
        logic      last;
        t_out_item last_cell;
        code = int'(item.text_byte);
        last = item.string_end;
        byte_cells.delete();
        if (!console_on) return;
        if (cursor_col >= screen_cols()) cursor_col = screen_cols() - 1;
        if (cursor_row >= screen_rows()) cursor_row = screen_rows() - 1;
        case (seq_state)
            SEQ_ESC: begin
                if (code == BRACKET_BYTE) begin
                    seq_state = SEQ_CSI;
                    digit_cnt = 0;
                    if (last) replay_sequence();
                end else begin
                    replay_sequence();
                    start_fresh(code, last);
                end
            end
            SEQ_CSI: begin
                if (code >= DIGIT0_BYTE && code <= DIGIT9_BYTE) begin
                    if (digit_cnt < MAX_DIGITS) begin
                        digit_buf[digit_cnt] = 4'(code - DIGIT0_BYTE);
                        digit_cnt++;
                        if (last) replay_sequence();
                    end else begin
                        replay_sequence();
                        void'(put_glyph(code));
                    end
                end else if (code == SGR_END_BYTE) begin
                    apply_color_code();
                end else begin
                    replay_sequence();
                    start_fresh(code, last);
                end
            end
            default: begin
                seq_state = SEQ_IDLE;
                start_fresh(code, last);
            end
        endcase
        if (byte_cells.size() > 0) begin
            last_cell = byte_cells.pop_back();
            last_cell.final_result = 1'b1;
            byte_cells.push_back(last_cell);
        end
        foreach (byte_cells[k]) expected_cells.push_back(byte_cells[k]);
    endfunction

    function automatic void check_field(input string field, input logic [COLOR_W-1:0] want,
                                        input logic [COLOR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            o_failures++;
        end
    endfunction

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            console_on     = 1'b0;
            screen_columns = COLS_W'(80);
            screen_lines   = LINES_W'(48);
            ink_default    = 32'h00FF_FFFF;
            ink_accent     = 32'h0000_FFFF;
            ink_dim        = 32'h0080_8080;
            ink_error      = 32'h00FF_0000;
            paper          = '0;
            cursor_col     = 0;
            cursor_row     = 0;
            ink_sel        = INK_DEFAULT;
            seq_state      = SEQ_IDLE;
            digit_cnt      = 0;
            foreach (digit_buf[k]) digit_buf[k] = '0;
            expected_cells.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ENABLE:     console_on = i_cfg_data[0];
                    CFG_COLUMNS:    screen_columns = i_cfg_data[COLS_W-1:0];
                    CFG_LINES:      screen_lines = i_cfg_data[LINES_W-1:0];
                    CFG_DEFAULT:    ink_default = i_cfg_data;
                    CFG_ACCENT:     ink_accent = i_cfg_data;
                    CFG_DIM:        ink_dim = i_cfg_data;
                    CFG_ERROR:      ink_error = i_cfg_data;
                    CFG_BACKGROUND: paper = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) predict_cell_commands(i_in_item);
            if (i_pop && !i_empty) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected cell command: command %0d column %0d row %0d",
                           i_out_item.command, i_out_item.cell_column, i_out_item.cell_row);
                    o_failures++;
                end else begin
                    want = expected_cells.pop_front();
                    check_field("command", want.command, i_out_item.command);
                    check_field("cell_column", want.cell_column, i_out_item.cell_column);
                    check_field("cell_row", want.cell_row, i_out_item.cell_row);
                    check_field("glyph_code", want.glyph_code, i_out_item.glyph_code);
                    check_field("ink_color", want.ink_color, i_out_item.ink_color);
                    check_field("paper_color", want.paper_color, i_out_item.paper_color);
                    check_field("final_result", want.final_result, i_out_item.final_result);
                end
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

/* dv/text_console_cursor_engine_top_test.sv */
// testbench top for the text console cursor engine: stimulus, idling and verdict
`timescale 1ns / 100ps
module text_console_cursor_engine_top_test;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 24;
    localparam int PHASE_BYTES      = 54;

    typedef logic [BYTE_W-1:0] t_byte_q [$];

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    t_in_item           in_item;
    logic               empty;
    logic               pop;
    t_out_item          out_item;
    logic               cfg_wr_en;
    t_cfg_index         cfg_index;
    logic [COLOR_W-1:0] cfg_data;

    int                 failures;
    int                 pending;
    int                 cycles;
    int                 hold_requests;
    int                 holds_served;
    int                 bytes_sent;
    bit                 burst_mode;
    bit                 console_on;

    text_console_cursor_engine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tcc_command_checker command_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in_item   (in_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("text_console_cursor_engine_top_test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // code < 0 gives the bare form with no digits
    function automatic t_byte_q color_sequence(input int code);
        t_byte_q text;
        text = {SGR_END_BYTE};
        if (code >= 0) begin
            do begin
                text.push_front(DIGIT0_BYTE + 8'(code % 10));
                code = code / 10;
            end while (code > 0);
        end
        text.push_front(BRACKET_BYTE);
        text.push_front(ESC_BYTE);
        return text;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] text, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    = 1'b1;
        in_item = '{text_byte: text, string_end: last};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (console_on) bytes_sent++;
    endtask

    task automatic send_string(input t_byte_q text, input logic end_on_last);
        foreach (text[k]) send_byte(text[k], end_on_last && (k == text.size() - 1));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index index, input logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic on, input int cols, input int rows,
                             input logic recolor);
        int k;
        wait_idle();
        write_reg(CFG_ENABLE, COLOR_W'(on));
        write_reg(CFG_COLUMNS, COLOR_W'(cols));
        write_reg(CFG_LINES, COLOR_W'(rows));
        if (recolor) begin
            for (k = CFG_DEFAULT; k <= CFG_BACKGROUND; k++) begin
                write_reg(t_cfg_index'(k), pick_color());
            end
        end
        @(negedge i_clk);
        cfg_wr_en  = 1'b0;
        console_on = on;
    endtask

    task automatic send_color_sequence();
        int pick;
        int code;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       code = -1;
            1:       code = int'(SGR_RESET);
            2:       code = int'(SGR_ACCENT);
            3:       code = int'(SGR_DIM);
            4, 5:    code = int'(SGR_ERROR);
            default: code = $urandom_range(0, 9999);
        endcase
        send_string(color_sequence(code), $urandom_range(0, 5) == 0);
    endtask

    task automatic send_broken_sequence();
        t_byte_q           text;
        int                n;
        logic [BYTE_W-1:0] breaker;
        text = {ESC_BYTE};
        if ($urandom_range(0, 4) != 0) begin
            text.push_back(BRACKET_BYTE);
            n = $urandom_range(0, MAX_DIGITS + 2);
            repeat (n) text.push_back(DIGIT0_BYTE + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) begin
            // cut off by the end of the string
            send_string(text, 1'b1);
        end else begin
            case ($urandom_range(0, 11))
                0:       breaker = ESC_BYTE;
                1:       breaker = BRACKET_BYTE;
                2:       breaker = LF_BYTE;
                3:       breaker = TAB_BYTE;
                4:       breaker = BS_BYTE;
                5:       breaker = CR_BYTE;
                default: breaker = 8'($urandom_range(0, 255));
            endcase
            text.push_back(breaker);
            send_string(text, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic send_plain_text();
        logic [BYTE_W-1:0] text;
        case ($urandom_range(0, 11))
            0:       text = LF_BYTE;
            1:       text = CR_BYTE;
            2:       text = TAB_BYTE;
            3:       text = BS_BYTE;
            4:       text = 8'($urandom_range(128, 255));
            5, 6:    text = 8'($urandom_range(0, 255));
            default: text = 8'($urandom_range(SPACE_BYTE, 8'h7E));
        endcase
        send_byte(text, $urandom_range(0, 7) == 0);
    endtask

    task automatic run_traffic(input int count);
        int goal;
        int pick;
        goal = bytes_sent + count;
        while (bytes_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) send_color_sequence();
            else if (pick < 55) send_broken_sequence();
            else send_plain_text();
        end
    endtask

    initial begin : receiver
        int stall;
        int held;
        pop   = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                pop  = 1'b0;
                held = 0;
                while (held < LONG_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                holds_served++;
            end else if (stall > 0) begin
                pop = 1'b0;
                stall--;
            end else begin
                pop   = 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin : stimulus
        t_byte_q text;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        in_item       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_ENABLE;
        cfg_data      = '0;
        hold_requests = 0;
        holds_served  = 0;
        bytes_sent    = 0;
        burst_mode    = 1'b0;
        console_on    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // console still disabled after reset
        repeat (4) send_plain_text();
        send_byte(ESC_BYTE, 1'b0);

        configure(1'b1, 8, 2, 1'b1);
        send_byte(BS_BYTE, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(CR_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(TAB_BYTE, 1'b0);
        send_byte(TAB_BYTE, 1'b0);
        send_byte(LF_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(BS_BYTE, 1'b0);
        send_string(color_sequence(int'(SGR_ERROR)), 1'b0);
        send_byte(8'h5A, 1'b0);
        text = {ESC_BYTE, BRACKET_BYTE};
        for (int k = 1; k <= MAX_DIGITS + 1; k++) text.push_back(DIGIT0_BYTE + 8'(k));
        send_string(text, 1'b0);
        send_byte(ESC_BYTE, 1'b1);
        send_string({ESC_BYTE, 8'h58}, 1'b0);
        send_string({ESC_BYTE, BRACKET_BYTE}, 1'b1);

        configure(1'b1, MAX_COLUMNS, MAX_LINES, 1'b1);
        run_traffic(PHASE_BYTES);
        configure(1'b1, 0, 0, 1'b0);
        run_traffic(PHASE_BYTES);

        configure(1'b1, 12, 3, 1'b1);
        hold_requests++;
        burst_mode = 1'b1;
        run_traffic(PHASE_BYTES);
        burst_mode = 1'b0;

        configure(1'b1, 511, 255, 1'b0);
        run_traffic(PHASE_BYTES);
        configure(1'b1, 1, 4, 1'b1);
        run_traffic(PHASE_BYTES);

        configure(1'b1, $urandom_range(2, 40), $urandom_range(1, 6), 1'b1);
        burst_mode = 1'b1;
        run_traffic(PHASE_BYTES);
        burst_mode = 1'b0;

        configure(1'b0, 80, 48, 1'b0);
        repeat (10) send_plain_text();
        send_byte(ESC_BYTE, 1'b0);
        configure(1'b1, 80, 48, 1'b1);
        run_traffic(PHASE_BYTES);
        configure(1'b1, 3, 2, 1'b1);
        run_traffic(PHASE_BYTES);

        wait_idle();
        if (failures == 0 && pending == 0) begin
            $display("text_console_cursor_engine_top_test passed");
        end else begin
            $display("text_console_cursor_engine_top_test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/tcc_pkg.sv
sv/tcc_front.sv
sv/tcc_job_queue.sv
sv/tcc_back.sv
sv/tcc_result_queue.sv
sv/text_console_cursor_engine_top.sv
dv/tcc_command_checker.sv
dv/text_console_cursor_engine_top_test.sv
